// File: rtl/core/assert_macros.svh
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define MI4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define MI4_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: rtl/core/mi4_pkg.sv
// package: widths, beat types, state and command types and an index helper for the 4x4 inverter
`default_nettype none
package mi4_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  // accumulator holds products up to the full determinant without wrap
  localparam int ACC_W       = 4 * VALUE_WIDTH + 6;
  // dividend and shifted divisor width
  localparam int DIV_W       = ACC_W + VALUE_WIDTH + 2 * FRAC_BITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef struct packed {
    logic [3:0]                    entry_index;
    logic signed [VALUE_WIDTH-1:0] entry_value;
    logic                          last_entry;
  } entry_t;

  typedef struct packed {
    logic [3:0]                    result_index;
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic signed [VALUE_WIDTH-1:0] determinant;
    logic                          singular;
    logic                          last_result;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_COF_MP,
    S_COF_MC,
    S_COF_RUN,
    S_COF_STORE,
    S_DET_MP,
    S_DET_MC,
    S_DET_RUN,
    S_DET_ABS,
    S_DET_SAT,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_DIV_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_ENTRY,
    SRC_TMP,
    SRC_COF
  } src_t;

  typedef struct packed {
    logic       entry_wr;
    logic [3:0] idx;
    logic       mp_load;
    logic       mc_load;
    src_t       src;
    logic       clr;
    logic       neg;
    logic       dst_acc;
    logic       mul_step;
    logic       mul_last;
    logic       cof_wr;
    logic       cof_neg;
    logic       det_abs;
    logic       det_sat;
    logic       div_load;
    logic       div_step;
    logic       div_first;
    logic       out_load;
    logic [3:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // entry index of element (i, j) of the 3x3 minor that drops row and column of k
  function automatic logic [3:0] minor_idx(input logic [3:0] k, input logic [1:0] i,
                                           input logic [1:0] j);
    logic [1:0] rr;
    logic [1:0] cc;
    rr = (i < k[3:2]) ? i : i + 2'd1;
    cc = (j < k[1:0]) ? j : j + 2'd1;
    return {rr, cc};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mi4_datapath.sv
// datapath: matrix store, bit-serial multiply-accumulate, cofactor store, divider, result register
`default_nettype none
module mi4_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mi4_pkg::entry_t    entry_data,
  input  wire mi4_pkg::dp_cmd_t   cmd,
  output mi4_pkg::dp_status_t     status,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output mi4_pkg::result_t        result_data
);

  localparam int V  = mi4_pkg::VALUE_WIDTH;
  localparam int F  = mi4_pkg::FRAC_BITS;
  localparam int W  = mi4_pkg::ACC_W;
  localparam int DW = mi4_pkg::DIV_W;

  logic [V-1:0]  mat [16];
  logic [W-1:0]  cof [16];
  logic [W-1:0]  acc;
  logic [W-1:0]  tmp;
  logic [W-1:0]  mcand;
  logic [V-1:0]  mplier;
  logic          mneg;
  logic          mdst;
  logic [W-1:0]  dmag;
  logic          dneg;
  logic          sing;
  logic [V-1:0]  det_out;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [V-2:0]  quo;
  logic          dsat;
  logic          cneg;

  logic [V-1:0]  rd_e;
  logic [W-1:0]  rd_c;
  logic [W-1:0]  mc_sel;
  logic [W-1:0]  addend;
  logic [W-1:0]  cmag;
  logic          ge;
  logic          qneg;
  logic [V-1:0]  qval;
  logic [V-1:0]  res_val;
  logic          dsat_hi;
  logic [V-1:0]  dmid;

  localparam logic [V-1:0] MAX_V = {1'b0, {(V-1){1'b1}}};
  localparam logic [V-1:0] MIN_V = {1'b1, {(V-1){1'b0}}};

  // single read port on each store
  assign rd_e = mat[cmd.idx];
  assign rd_c = cof[cmd.idx];

  // multiplicand source, signed addend for one multiplier bit, cofactor magnitude and divider compare
  always_comb begin
    unique case (cmd.src)
      mi4_pkg::SRC_ENTRY: mc_sel = {{(W-V){rd_e[V-1]}}, rd_e};
      mi4_pkg::SRC_TMP:   mc_sel = tmp;
      mi4_pkg::SRC_COF:   mc_sel = rd_c;
      default:            mc_sel = '0;
    endcase
    addend = (mneg ^ cmd.mul_last) ? (~mcand + W'(1)) : mcand;
    cmag   = rd_c[W-1] ? (~rd_c + W'(1)) : rd_c;
    ge     = (rem >= dsh);
  end

  // matrix store, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] <= '0;
    end else if (cmd.entry_wr) begin
      mat[entry_data.entry_index] <= entry_data.entry_value;
    end
  end

  // cofactor store
  always_ff @(posedge clk) begin
    if (cmd.cof_wr) cof[cmd.idx] <= cmd.cof_neg ? (~acc + W'(1)) : acc;
  end

  // shift-add multiplier, signed multiplier bit weight on the last step
  always_ff @(posedge clk) begin
    if (cmd.mp_load) mplier <= rd_e;
    if (cmd.mc_load) begin
      mcand <= mc_sel;
      mneg  <= cmd.neg;
      mdst  <= cmd.dst_acc;
      if (cmd.clr && cmd.dst_acc) acc <= '0;
      if (cmd.clr && !cmd.dst_acc) tmp <= '0;
    end
    if (cmd.mul_step) begin
      if (mplier[0]) begin
        if (mdst) acc <= acc + addend;
        else      tmp <= tmp + addend;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  // determinant magnitude and saturated output form
  assign dsat_hi = |dmag[W-1:3*F+V-1];
  assign dmid    = dmag[3*F +: V];

  always_ff @(posedge clk) begin
    if (cmd.det_abs) begin
      dneg <= acc[W-1];
      sing <= (acc == '0);
      dmag <= acc[W-1] ? (~acc + W'(1)) : acc;
    end
    if (cmd.det_sat) begin
      if (dsat_hi) det_out <= dneg ? MIN_V : MAX_V;
      else         det_out <= dneg ? (~dmid + V'(1)) : dmid;
    end
  end

  // restoring divider: first step checks saturation, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      cneg <= rd_c[W-1];
      rem  <= {{(DW-W){1'b0}}, cmag} << (2 * F);
      dsh  <= {{(DW-W){1'b0}}, dmag} << (V - 1);
      quo  <= '0;
      dsat <= 1'b0;
    end
    if (cmd.div_step) begin
      if (cmd.div_first) begin
        dsat <= ge;
      end else begin
        if (ge) rem <= rem - dsh;
        quo <= {quo[V-3:0], ge};
      end
      dsh <= dsh >> 1;
    end
  end

  // signed, saturated quotient, zero for a singular matrix
  always_comb begin
    qneg = cneg ^ dneg;
    qval = {1'b0, quo};
    if (sing)      res_val = '0;
    else if (dsat) res_val = qneg ? MIN_V : MAX_V;
    else           res_val = qneg ? (~qval + V'(1)) : qval;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      result_data.result_index <= cmd.out_idx;
      result_data.result_value <= res_val;
      result_data.determinant  <= det_out;
      result_data.singular     <= sing;
      result_data.last_result  <= (cmd.out_idx == 4'd15);
    end
  end

  assign status.out_busy = result_valid & result_stall;

endmodule
`default_nettype wire

// File: rtl/core/mi4_ctrl.sv
// controller: sequences loading, cofactor products, determinant, division and output
`default_nettype none
module mi4_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                entry_valid,
  input  wire logic                last_entry,
  output logic                     entry_stall,
  input  wire mi4_pkg::dp_status_t status,
  output mi4_pkg::dp_cmd_t         cmd
);

  localparam int CW = mi4_pkg::CNT_W;
  localparam logic [CW-1:0] LAST_BIT = CW'(mi4_pkg::VALUE_WIDTH - 1);

  mi4_pkg::state_t state, state_next;
  logic [3:0]    k;
  logic [1:0]    t;
  logic [1:0]    m;
  logic [CW-1:0] bitcnt;
  logic          bit_end;
  logic [1:0]    col_x;
  logic [1:0]    col_y;

  assign bit_end = (bitcnt == LAST_BIT);
  assign col_x   = (t == 2'd0) ? 2'd1 : 2'd0;
  assign col_y   = (t == 2'd2) ? 2'd1 : 2'd2;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mi4_pkg::S_LOAD:      if (entry_valid && last_entry) state_next = mi4_pkg::S_COF_MP;
      mi4_pkg::S_COF_MP:    state_next = mi4_pkg::S_COF_MC;
      mi4_pkg::S_COF_MC:    state_next = mi4_pkg::S_COF_RUN;
      mi4_pkg::S_COF_RUN: begin
        if (bit_end) begin
          if (m == 2'd2 && t == 2'd2) state_next = mi4_pkg::S_COF_STORE;
          else                        state_next = mi4_pkg::S_COF_MP;
        end
      end
      mi4_pkg::S_COF_STORE: state_next = (k == 4'd15) ? mi4_pkg::S_DET_MP : mi4_pkg::S_COF_MP;
      mi4_pkg::S_DET_MP:    state_next = mi4_pkg::S_DET_MC;
      mi4_pkg::S_DET_MC:    state_next = mi4_pkg::S_DET_RUN;
      mi4_pkg::S_DET_RUN: begin
        if (bit_end) state_next = (k == 4'd3) ? mi4_pkg::S_DET_ABS : mi4_pkg::S_DET_MP;
      end
      mi4_pkg::S_DET_ABS:   state_next = mi4_pkg::S_DET_SAT;
      mi4_pkg::S_DET_SAT:   state_next = mi4_pkg::S_DIV_LOAD;
      mi4_pkg::S_DIV_LOAD:  state_next = mi4_pkg::S_DIV_RUN;
      mi4_pkg::S_DIV_RUN:   if (bit_end) state_next = mi4_pkg::S_DIV_DONE;
      mi4_pkg::S_DIV_DONE: begin
        if (!status.out_busy) begin
          state_next = (k == 4'd15) ? mi4_pkg::S_LOAD : mi4_pkg::S_DIV_LOAD;
        end
      end
      default:              state_next = mi4_pkg::S_LOAD;
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mi4_pkg::S_LOAD;
      k      <= '0;
      t      <= '0;
      m      <= '0;
      bitcnt <= '0;
    end else begin
      state <= state_next;
      if (state == mi4_pkg::S_COF_RUN || state == mi4_pkg::S_DET_RUN ||
          state == mi4_pkg::S_DIV_RUN) begin
        bitcnt <= bit_end ? '0 : bitcnt + CW'(1);
      end
      unique case (state)
        mi4_pkg::S_COF_RUN: begin
          if (bit_end) begin
            if (m != 2'd2) begin
              m <= m + 2'd1;
            end else if (t != 2'd2) begin
              m <= '0;
              t <= t + 2'd1;
            end
          end
        end
        mi4_pkg::S_COF_STORE: begin
          k <= k + 4'd1;
          t <= '0;
          m <= '0;
        end
        mi4_pkg::S_DET_RUN: begin
          if (bit_end) k <= (k == 4'd3) ? 4'd0 : k + 4'd1;
        end
        mi4_pkg::S_DIV_DONE: begin
          if (!status.out_busy) k <= k + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.src     = mi4_pkg::SRC_ENTRY;
    cmd.out_idx = k;
    entry_stall = (state != mi4_pkg::S_LOAD);
    unique case (state)
      mi4_pkg::S_LOAD: begin
        cmd.entry_wr = entry_valid;
      end
      mi4_pkg::S_COF_MP: begin
        cmd.mp_load = 1'b1;
        unique case (m)
          2'd0:    cmd.idx = mi4_pkg::minor_idx(k, 2'd1, col_x);
          2'd1:    cmd.idx = mi4_pkg::minor_idx(k, 2'd1, col_y);
          default: cmd.idx = mi4_pkg::minor_idx(k, 2'd0, t);
        endcase
      end
      mi4_pkg::S_COF_MC: begin
        cmd.mc_load = 1'b1;
        unique case (m)
          2'd0: begin
            cmd.idx = mi4_pkg::minor_idx(k, 2'd2, col_y);
            cmd.clr = 1'b1;
          end
          2'd1: begin
            cmd.idx = mi4_pkg::minor_idx(k, 2'd2, col_x);
            cmd.neg = 1'b1;
          end
          default: begin
            cmd.src     = mi4_pkg::SRC_TMP;
            cmd.dst_acc = 1'b1;
            cmd.clr     = (t == 2'd0);
            cmd.neg     = (t == 2'd1);
          end
        endcase
      end
      mi4_pkg::S_COF_RUN, mi4_pkg::S_DET_RUN: begin
        cmd.mul_step = 1'b1;
        cmd.mul_last = bit_end;
      end
      mi4_pkg::S_COF_STORE: begin
        cmd.idx     = k;
        cmd.cof_wr  = 1'b1;
        cmd.cof_neg = k[2] ^ k[0];
      end
      mi4_pkg::S_DET_MP: begin
        cmd.idx     = k;
        cmd.mp_load = 1'b1;
      end
      mi4_pkg::S_DET_MC: begin
        cmd.idx     = k;
        cmd.mc_load = 1'b1;
        cmd.src     = mi4_pkg::SRC_COF;
        cmd.dst_acc = 1'b1;
        cmd.clr     = (k == 4'd0);
      end
      mi4_pkg::S_DET_ABS:  cmd.det_abs = 1'b1;
      mi4_pkg::S_DET_SAT:  cmd.det_sat = 1'b1;
      mi4_pkg::S_DIV_LOAD: begin
        // inverse entry (r, c) takes the cofactor at (c, r)
        cmd.idx      = {k[1:0], k[3:2]};
        cmd.div_load = 1'b1;
      end
      mi4_pkg::S_DIV_RUN: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (bitcnt == '0);
      end
      mi4_pkg::S_DIV_DONE: cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/matrix_inverse_4x4.sv
// top level: 4x4 fixed-point matrix inverse by adjugate
//
//   channel | direction | handshake                  | beat
//   entry   | in        | entry_valid / entry_stall  | mi4_pkg::entry_t
//   result  | out       | result_valid / result_stall| mi4_pkg::result_t
//
// a beat without last_entry is stored when it is taken; the next can follow at once
// after the last entry, the first result waits for sixteen cofactors of nine
// bit-serial products each on the one shared multiply-accumulate unit, then
// four for the determinant
// each result then takes one divider pass
// synchronous reset clears the matrix to zeros and the sequencer to loading
// a stalled result holds the sequencer; the last result may wait while loading resumes
`default_nettype none
module matrix_inverse_4x4 (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             entry_valid,
  output logic                  entry_stall,
  input  wire mi4_pkg::entry_t  entry_data,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output mi4_pkg::result_t      result_data
);

  mi4_pkg::dp_cmd_t    cmd;
  mi4_pkg::dp_status_t status;

  // sequencer
  mi4_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (entry_valid),
    .last_entry  (entry_data.last_entry),
    .entry_stall (entry_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // arithmetic and storage
  mi4_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .entry_data   (entry_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/mi4_checker.sv
// port-level checks on the 4x4 inverter, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mi4_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             entry_valid,
  input wire logic             entry_stall,
  input wire mi4_pkg::entry_t  entry_data,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire mi4_pkg::result_t result_data
);

  // a stalled result beat holds
  `MI4_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data), "result beat changed under stall")

  // singular matrix gives zero entries
  `MI4_ASSERT(a_sing_zero, result_valid && result_data.singular |-> result_data.result_value == '0, "singular result not zero")

  // singular matrix gives zero determinant
  `MI4_ASSERT(a_sing_det, result_valid && result_data.singular |-> result_data.determinant == '0, "singular determinant not zero")

  // no loading between results of one run
  `MI4_ASSERT(a_run_busy, result_valid && !result_data.last_result |-> entry_stall, "entry taken mid run")

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);
`default_nettype wire
